### src/sbqt_pkg.sv
// Package for the semaphore blocked-queue table.
// Field widths, request and status codes, sequencer states, compare result struct.
package sbqt_pkg;

   localparam int KEY_W         = 31;
   localparam int PID_W         = 5;
   localparam int DEF_MAX_PROCS = 32;

   typedef enum logic [1:0] {
      REQ_INSERT  = 2'd0,
      REQ_REMOVE  = 2'd1,
      REQ_TAKEOUT = 2'd2,
      REQ_PEEK    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NOTFOUND = 2'd2
   } status_code_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_ACT,
      FSM_WALK,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      logic key_eq;
      logic pid_eq;
      logic tail_eq;
   } cmp_result_type;

endpackage

### src/sbqt_cmp.sv
// Shared compare unit of the semaphore table sequencer.
// Key match for the descriptor scan, process and tail match for the queue walk.
// Depends on sbqt_pkg.
module sbqt_cmp (
   input  logic [sbqt_pkg::KEY_W-1:0] a_key,
   input  logic [sbqt_pkg::KEY_W-1:0] b_key,
   input  logic [sbqt_pkg::PID_W-1:0] cur,
   input  logic [sbqt_pkg::PID_W-1:0] pid,
   input  logic [sbqt_pkg::PID_W-1:0] tail,
   output sbqt_pkg::cmp_result_type   res
);

   always_comb begin
      res.key_eq  = (a_key == b_key);
      res.pid_eq  = (cur == pid);
      res.tail_eq = (cur == tail);
   end

endmodule

### src/semaphore_blocked_queue_table_top.sv
// Semaphore blocked-queue table: one item at a time under a small sequencer.
// Each accepted request scans the descriptors, one per cycle, through the shared comparator;
// take-out then walks the blocked queue of the matching descriptor. Early rejects skip the
// scan and answer directly. One item at a time: not ready until the result is in the output
// register and the sequencer is back in idle.
// Reset (synchronous): all descriptors free, no process blocked, no result pending.
// Depends on sbqt_pkg and sbqt_cmp.
module semaphore_blocked_queue_table_top #(
   parameter int MAX_PROCS = sbqt_pkg::DEF_MAX_PROCS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_req_type,
   input  logic [sbqt_pkg::KEY_W-1:0] req_sem_key,
   input  logic [sbqt_pkg::PID_W-1:0] req_proc_id,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [sbqt_pkg::PID_W-1:0] rsp_result_proc
);

   localparam int DW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int KW = sbqt_pkg::KEY_W;
   localparam int PW = sbqt_pkg::PID_W;

   sbqt_pkg::fsm_state_type state_ff, state_in;

   logic [1:0]    rt_ff;
   logic [KW-1:0] key_ff;
   logic [PW-1:0] pid_ff;
   logic [DW-1:0] cnt_ff;
   logic [DW-1:0] d_ff;
   logic [DW-1:0] free_ff;
   logic          free_ok_ff;
   logic [PW-1:0] cur_ff;
   logic [PW-1:0] prev_ff;
   logic          first_ff;
   logic [1:0]    done_status_ff;
   logic [PW-1:0] done_proc_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [PW-1:0] rsp_proc_ff;

   logic [KW-1:0]        desc_key_ff  [MAX_PROCS];
   logic [MAX_PROCS-1:0] desc_active_ff;
   logic [PW-1:0]        head_ff      [MAX_PROCS];
   logic [PW-1:0]        tail_ff      [MAX_PROCS];
   logic [PW-1:0]        next_ff      [MAX_PROCS];
   logic [KW-1:0]        wait_ff      [MAX_PROCS];

   logic                     accept;
   logic                     pid_ok;
   logic [KW-1:0]            wait_req;
   logic [KW-1:0]            scan_key;
   logic                     scan_act;
   logic                     match;
   logic                     last;
   logic [PW-1:0]            head_d;
   logic [PW-1:0]            tail_d;
   logic [PW-1:0]            cmp_cur;
   logic [PW-1:0]            next_cur;
   logic                     cur_ok;
   logic                     early_fail;
   sbqt_pkg::cmp_result_type res;

   assign req_ready = (state_ff == sbqt_pkg::FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign pid_ok    = (32'(req_proc_id) < MAX_PROCS);
   assign wait_req  = wait_ff[DW'(req_proc_id)];
   assign scan_key  = desc_key_ff[cnt_ff];
   assign scan_act  = desc_active_ff[cnt_ff];
   assign head_d    = head_ff[d_ff];
   assign tail_d    = tail_ff[d_ff];
   assign cmp_cur   = (state_ff == sbqt_pkg::FSM_ACT) ? head_d : cur_ff;
   assign next_cur  = next_ff[DW'(cmp_cur)];
   assign cur_ok    = (32'(cur_ff) < MAX_PROCS);
   assign match     = scan_act && res.key_eq;
   assign last      = (cnt_ff == DW'(MAX_PROCS - 1));

   always_comb begin
      case (sbqt_pkg::req_code_type'(req_req_type))
         sbqt_pkg::REQ_INSERT:
            early_fail = (req_sem_key == '0) || !pid_ok || (wait_req != '0);
         sbqt_pkg::REQ_TAKEOUT:
            early_fail = !pid_ok || (wait_req == '0);
         default:
            early_fail = (req_sem_key == '0);
      endcase
   end

   sbqt_cmp u_cmp (
      .a_key (scan_key),
      .b_key (key_ff),
      .cur   (cmp_cur),
      .pid   (pid_ff),
      .tail  (tail_d),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbqt_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbqt_pkg::FSM_IDLE: begin
            if (accept) state_in = early_fail ? sbqt_pkg::FSM_DONE : sbqt_pkg::FSM_SCAN;
         end
         sbqt_pkg::FSM_SCAN: begin
            if (match) state_in = sbqt_pkg::FSM_ACT;
            else if (last) state_in = sbqt_pkg::FSM_DONE;
         end
         sbqt_pkg::FSM_ACT: begin
            state_in = (rt_ff == sbqt_pkg::REQ_TAKEOUT) ? sbqt_pkg::FSM_WALK
                                                         : sbqt_pkg::FSM_DONE;
         end
         sbqt_pkg::FSM_WALK: begin
            if (!cur_ok || res.pid_eq || res.tail_eq || last) state_in = sbqt_pkg::FSM_DONE;
         end
         sbqt_pkg::FSM_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = sbqt_pkg::FSM_IDLE;
         end
         default: state_in = sbqt_pkg::FSM_IDLE;
      endcase
   end

   // Sequencer datapath and table updates
   always_ff @(posedge clock) begin
      if (reset) begin
         desc_active_ff <= '0;
         for (int i = 0; i < MAX_PROCS; i++) wait_ff[i] <= '0;
      end else begin
         case (state_ff)
            sbqt_pkg::FSM_IDLE: begin
               if (accept) begin
                  rt_ff          <= req_req_type;
                  pid_ff         <= req_proc_id;
                  key_ff         <= (req_req_type == sbqt_pkg::REQ_TAKEOUT) ? wait_req
                                                                            : req_sem_key;
                  cnt_ff         <= '0;
                  free_ok_ff     <= 1'b0;
                  done_status_ff <= sbqt_pkg::STAT_NOTFOUND;
                  done_proc_ff   <= '0;
               end
            end
            sbqt_pkg::FSM_SCAN: begin
               if (match) begin
                  d_ff <= cnt_ff;
               end else begin
                  if (!scan_act && !free_ok_ff) begin
                     free_ff    <= cnt_ff;
                     free_ok_ff <= 1'b1;
                  end
                  if (last) begin
                     if (rt_ff == sbqt_pkg::REQ_INSERT) begin
                        if (free_ok_ff || !scan_act) begin
                           // take the lowest free descriptor for the new key
                           desc_active_ff[free_ok_ff ? free_ff : cnt_ff] <= 1'b1;
                           desc_key_ff[free_ok_ff ? free_ff : cnt_ff]    <= key_ff;
                           head_ff[free_ok_ff ? free_ff : cnt_ff]        <= pid_ff;
                           tail_ff[free_ok_ff ? free_ff : cnt_ff]        <= pid_ff;
                           wait_ff[DW'(pid_ff)]                          <= key_ff;
                           done_status_ff <= sbqt_pkg::STAT_OK;
                        end else begin
                           done_status_ff <= sbqt_pkg::STAT_FULL;
                        end
                     end
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            sbqt_pkg::FSM_ACT: begin
               case (sbqt_pkg::req_code_type'(rt_ff))
                  sbqt_pkg::REQ_INSERT: begin
                     next_ff[DW'(tail_d)] <= pid_ff;
                     tail_ff[d_ff]        <= pid_ff;
                     wait_ff[DW'(pid_ff)] <= key_ff;
                     done_status_ff       <= sbqt_pkg::STAT_OK;
                  end
                  sbqt_pkg::REQ_REMOVE: begin
                     if (res.tail_eq) desc_active_ff[d_ff] <= 1'b0;
                     else head_ff[d_ff] <= next_cur;
                     wait_ff[DW'(head_d)] <= '0;
                     done_status_ff       <= sbqt_pkg::STAT_OK;
                     done_proc_ff         <= head_d;
                  end
                  sbqt_pkg::REQ_PEEK: begin
                     done_status_ff <= sbqt_pkg::STAT_OK;
                     done_proc_ff   <= head_d;
                  end
                  default: begin
                     cur_ff   <= head_d;
                     first_ff <= 1'b1;
                     cnt_ff   <= '0;
                  end
               endcase
            end
            sbqt_pkg::FSM_WALK: begin
               if (cur_ok && res.pid_eq) begin
                  if (first_ff) begin
                     if (res.tail_eq) desc_active_ff[d_ff] <= 1'b0;
                     else head_ff[d_ff] <= next_cur;
                  end else begin
                     // unlink from the middle; pull the tail back if needed
                     next_ff[DW'(prev_ff)] <= next_cur;
                     if (res.tail_eq) tail_ff[d_ff] <= prev_ff;
                  end
                  wait_ff[DW'(pid_ff)] <= '0;
                  done_status_ff       <= sbqt_pkg::STAT_OK;
                  done_proc_ff         <= pid_ff;
               end else if (cur_ok && !res.tail_eq) begin
                  prev_ff  <= cur_ff;
                  first_ff <= 1'b0;
                  cur_ff   <= next_cur;
                  cnt_ff   <= cnt_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Output register: holds the item until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == sbqt_pkg::FSM_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff  <= 1'b1;
         rsp_status_ff <= done_status_ff;
         rsp_proc_ff   <= done_proc_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_proc = rsp_proc_ff;

endmodule
